// File: design/go_back_n_sender_window_macros.svh
// Assertion macros used by the checker file of the Go-Back-N sender window.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef GO_BACK_N_SENDER_WINDOW_MACROS_SVH
`define GO_BACK_N_SENDER_WINDOW_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GBN_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GBN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/gbn_pkg.sv
// Shared types, codes and constants of the Go-Back-N sender window.
// No dependencies; every other design file but the macros header imports this package.
package gbn_pkg;

  localparam int GBN_SEQ_SPACE     = 8;
  localparam int GBN_PAYLOAD_WIDTH = 32;
  localparam int MAX_LENGTH        = 255;
  localparam int BURST_LIMIT       = 4;
  localparam int QUEUE_DEPTH       = 2;

  localparam int CMD_W = 2;
  localparam int PAY_W = 32;
  localparam int LEN_W = 8;
  localparam int SQF_W = 3;
  localparam int KND_W = 3;
  localparam int TMR_W = 2;
  localparam int WIN_W = 3;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 3'd4;
  // Register index of window_size, taken from paddr[2].
  localparam logic REG_WINDOW_SIZE = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND    = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [KND_W-1:0] {
    RES_TRANSMIT     = 3'd0,
    RES_REFUSED      = 3'd1,
    RES_ACK_ACCEPTED = 3'd2,
    RES_ACK_IGNORED  = 3'd3,
    RES_IDLE_TIMEOUT = 3'd4
  } res_kind_t;

  typedef enum logic [TMR_W-1:0] {
    TMR_NONE  = 2'd0,
    TMR_START = 2'd1,
    TMR_STOP  = 2'd2
  } tmr_t;

  typedef enum logic [2:0] {
    OP_SEND,
    OP_REFUSE,
    OP_ACK,
    OP_ACK_BAD,
    OP_TIMEOUT
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [PAY_W-1:0]  payload;
    logic [LEN_W-1:0]  length;
    logic [SQF_W-1:0]  ack_seq;
  } op_t;

endpackage

// File: design/gbn_front.sv
// Front end: classifies each accepted command into a queue operation.
// Depends on gbn_pkg; feeds gbn_queue.
module gbn_front #(
  parameter int SEQ_SPACE = gbn_pkg::GBN_SEQ_SPACE
) (
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [gbn_pkg::CMD_W-1:0] in_command,
  input  logic [gbn_pkg::PAY_W-1:0] in_payload,
  input  logic [gbn_pkg::LEN_W-1:0] in_payload_length,
  input  logic [gbn_pkg::SQF_W-1:0] in_ack_sequence,
  input  logic                      in_ack_checksum_good,
  input  logic                      in_ack_type_is_ack,
  input  logic                      q_full,
  output logic                      q_push,
  output gbn_pkg::op_t              q_op
);
  import gbn_pkg::*;

  logic len_ok;
  logic ack_ok;
  logic known;

  assign len_ok = (in_payload_length != '0) &&
                  (17'(in_payload_length) <= 17'(MAX_LENGTH));
  assign ack_ok = (32'(in_ack_sequence) < SEQ_SPACE) &&
                  in_ack_checksum_good && in_ack_type_is_ack;

  always_comb begin
    known        = 1'b1;
    q_op.kind    = OP_REFUSE;
    q_op.payload = in_payload;
    q_op.length  = in_payload_length;
    q_op.ack_seq = in_ack_sequence;
    case (cmd_t'(in_command))
      CMD_SEND:    q_op.kind = len_ok ? OP_SEND : OP_REFUSE;
      CMD_ACK:     q_op.kind = ack_ok ? OP_ACK : OP_ACK_BAD;
      CMD_TIMEOUT: q_op.kind = OP_TIMEOUT;
      default:     known = 1'b0;
    endcase
  end

  // An unknown command is taken and dropped, it yields no result.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && known;

endmodule

// File: design/gbn_queue.sv
// Short FIFO of classified operations between the front and back ends.
// Depends on gbn_pkg for the operation type.
module gbn_queue #(
  parameter int DEPTH = gbn_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  gbn_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output gbn_pkg::op_t head_op
);
  import gbn_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_op    = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// File: design/gbn_back.sv
// Back end: window state, packet buffer, replay sequencer and result register.
// Depends on gbn_pkg; takes operations from gbn_queue.
module gbn_back #(
  parameter int SEQ_SPACE     = gbn_pkg::GBN_SEQ_SPACE,
  parameter int PAYLOAD_WIDTH = gbn_pkg::GBN_PAYLOAD_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [gbn_pkg::WIN_W-1:0] window_size,
  input  logic                      op_valid,
  input  gbn_pkg::op_t              op,
  output logic                      op_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [gbn_pkg::KND_W-1:0] out_result_kind,
  output logic [gbn_pkg::SQF_W-1:0] out_sequence_number,
  output logic [gbn_pkg::PAY_W-1:0] out_payload,
  output logic [gbn_pkg::LEN_W-1:0] out_length,
  output logic [gbn_pkg::TMR_W-1:0] out_timer_action,
  output logic [gbn_pkg::SQF_W-1:0] out_outstanding_count,
  output logic                      out_last_result
);
  import gbn_pkg::*;

  localparam int SEQ_W   = $clog2(SEQ_SPACE);
  localparam int CW      = (SEQ_W > WIN_W) ? SEQ_W : WIN_W;
  localparam int WIN_CAP = (BURST_LIMIT < SEQ_SPACE - 1) ? BURST_LIMIT : SEQ_SPACE - 1;
  localparam logic [SEQ_W:0] SS = (SEQ_W + 1)'(SEQ_SPACE);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_REPLAY
  } state_t;

  function automatic logic [SEQ_W-1:0] mod_add(input logic [SEQ_W-1:0] a,
                                               input logic [SEQ_W-1:0] b);
    logic [SEQ_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SS) begin
      s = s - SS;
    end
    return s[SEQ_W-1:0];
  endfunction

  function automatic logic [SEQ_W-1:0] mod_sub(input logic [SEQ_W-1:0] a,
                                               input logic [SEQ_W-1:0] b);
    logic [SEQ_W:0] s;
    s = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      s = s + SS;
    end
    return s[SEQ_W-1:0];
  endfunction

  function automatic logic [SEQ_W-1:0] mod_inc(input logic [SEQ_W-1:0] a);
    logic [SEQ_W:0] s;
    s = {1'b0, a} + 1'b1;
    if (s == SS) begin
      s = '0;
    end
    return s[SEQ_W-1:0];
  endfunction

  function automatic logic [SQF_W-1:0] to_field(input logic [SEQ_W-1:0] v);
    logic [SEQ_W+SQF_W-1:0] e;
    e = {{SQF_W{1'b0}}, v};
    return e[SQF_W-1:0];
  endfunction

  // Packet buffer, one entry per sequence number.
  logic [PAYLOAD_WIDTH-1:0] pay_mem [SEQ_SPACE];
  logic [LEN_W-1:0]         len_mem [SEQ_SPACE];
  logic [PAYLOAD_WIDTH-1:0] rd_pay_r;
  logic [LEN_W-1:0]         rd_len_r;
  logic [SEQ_W-1:0]         rd_addr;
  logic                     mem_we;
  logic [PAYLOAD_WIDTH-1:0] wr_pay;

  state_t           state_r, state_nxt;
  logic [SEQ_W-1:0] base_r, base_nxt;
  logic [SEQ_W-1:0] next_r, next_nxt;
  logic [SEQ_W-1:0] idx_r, idx_nxt;
  logic [SEQ_W-1:0] burst_r, burst_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [KND_W-1:0] kind_r, kind_nxt;
  logic [SQF_W-1:0] seq_r, seq_nxt;
  logic [PAY_W-1:0] pay_r, pay_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [TMR_W-1:0] tmr_r, tmr_nxt;
  logic [SQF_W-1:0] cnt_r, cnt_nxt;
  logic             last_r, last_nxt;

  logic [SEQ_W-1:0]         count;
  logic [WIN_W-1:0]         win;
  logic [CW-1:0]            burst_c;
  logic [SEQ_W-1:0]         ack_s;
  logic [SEQ_W-1:0]         ack_dist;
  logic [SEQ_W-1:0]         ack_base;
  logic                     ack_ok;
  logic                     room;
  logic                     slot_free;
  logic [SEQ_W-1:0]         cur_addr;
  logic [SEQ_W-1:0]         nxt_addr;
  logic [PAYLOAD_WIDTH+PAY_W-1:0] in_ext;
  logic [PAYLOAD_WIDTH+PAY_W-1:0] wr_ext;
  logic [PAYLOAD_WIDTH+PAY_W-1:0] rd_ext;
  logic [SEQ_W+SQF_W-1:0]         ack_ext;

  assign count = mod_sub(next_r, base_r);
  assign win   = (window_size > WIN_W'(WIN_CAP)) ? WIN_W'(WIN_CAP) : window_size;
  assign room  = CW'(count) < CW'(win);
  assign burst_c = (CW'(count) > CW'(BURST_LIMIT)) ? CW'(BURST_LIMIT) : CW'(count);

  assign ack_ext  = {{SEQ_W{1'b0}}, op.ack_seq};
  assign ack_s    = ack_ext[SEQ_W-1:0];
  assign ack_dist = mod_sub(ack_s, base_r);
  assign ack_ok   = (CW'(ack_dist) < CW'(win)) && (ack_dist < count);
  assign ack_base = mod_inc(ack_s);

  // The stored payload keeps PAYLOAD_WIDTH bits; the result field is 32 bits.
  assign in_ext = {{PAYLOAD_WIDTH{1'b0}}, op.payload};
  assign wr_pay = in_ext[PAYLOAD_WIDTH-1:0];
  assign wr_ext = {{PAY_W{1'b0}}, wr_pay};
  assign rd_ext = {{PAY_W{1'b0}}, rd_pay_r};

  assign slot_free = !out_valid_r || !out_stall;
  assign cur_addr  = mod_add(base_r, idx_r);
  assign nxt_addr  = mod_add(base_r, idx_r + 1'b1);

  always_comb begin
    state_nxt     = state_r;
    base_nxt      = base_r;
    next_nxt      = next_r;
    idx_nxt       = idx_r;
    burst_nxt     = burst_r;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    seq_nxt       = seq_r;
    pay_nxt       = pay_r;
    len_nxt       = len_r;
    tmr_nxt       = tmr_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    op_pop        = 1'b0;
    mem_we        = 1'b0;
    rd_addr       = base_r;
    case (state_r)
      ST_IDLE: begin
        if (op_valid && slot_free) begin
          op_pop        = 1'b1;
          out_valid_nxt = 1'b1;
          kind_nxt      = RES_REFUSED;
          seq_nxt       = to_field(base_r);
          pay_nxt       = '0;
          len_nxt       = '0;
          tmr_nxt       = TMR_NONE;
          cnt_nxt       = to_field(count);
          last_nxt      = 1'b1;
          case (op.kind)
            OP_SEND: begin
              if (room) begin
                kind_nxt = RES_TRANSMIT;
                seq_nxt  = to_field(next_r);
                pay_nxt  = wr_ext[PAY_W-1:0];
                len_nxt  = op.length;
                tmr_nxt  = (count == '0) ? TMR_START : TMR_NONE;
                cnt_nxt  = to_field(count + 1'b1);
                mem_we   = 1'b1;
                next_nxt = mod_inc(next_r);
              end
            end
            OP_REFUSE: kind_nxt = RES_REFUSED;
            OP_ACK: begin
              if (ack_ok) begin
                kind_nxt = RES_ACK_ACCEPTED;
                base_nxt = ack_base;
                seq_nxt  = to_field(ack_base);
                cnt_nxt  = to_field(count - ack_dist - 1'b1);
                tmr_nxt  = (count - ack_dist == SEQ_W'(1)) ? TMR_STOP : TMR_NONE;
              end else begin
                kind_nxt = RES_ACK_IGNORED;
              end
            end
            OP_ACK_BAD: kind_nxt = RES_ACK_IGNORED;
            OP_TIMEOUT: begin
              if (count == '0) begin
                kind_nxt = RES_IDLE_TIMEOUT;
              end else begin
                // The buffer read at the base issued now is ready next cycle.
                out_valid_nxt = 1'b0;
                state_nxt     = ST_REPLAY;
                idx_nxt       = '0;
                burst_nxt     = burst_c[SEQ_W-1:0];
              end
            end
            default: out_valid_nxt = 1'b0;
          endcase
        end
      end
      ST_REPLAY: begin
        rd_addr = cur_addr;
        if (slot_free) begin
          rd_addr       = nxt_addr;
          out_valid_nxt = 1'b1;
          kind_nxt      = RES_TRANSMIT;
          seq_nxt       = to_field(cur_addr);
          pay_nxt       = rd_ext[PAY_W-1:0];
          len_nxt       = rd_len_r;
          tmr_nxt       = (idx_r == '0) ? TMR_START : TMR_NONE;
          cnt_nxt       = to_field(count);
          last_nxt      = (idx_r + 1'b1 == burst_r);
          idx_nxt       = idx_r + 1'b1;
          if (idx_r + 1'b1 == burst_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pay_mem[next_r] <= wr_pay;
      len_mem[next_r] <= op.length;
    end
    rd_pay_r <= pay_mem[rd_addr];
    rd_len_r <= len_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= '0;
      next_r      <= '0;
      idx_r       <= '0;
      burst_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      next_r      <= next_nxt;
      idx_r       <= idx_nxt;
      burst_r     <= burst_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r <= kind_nxt;
    seq_r  <= seq_nxt;
    pay_r  <= pay_nxt;
    len_r  <= len_nxt;
    tmr_r  <= tmr_nxt;
    cnt_r  <= cnt_nxt;
    last_r <= last_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_result_kind       = kind_r;
  assign out_sequence_number   = seq_r;
  assign out_payload           = pay_r;
  assign out_length            = len_r;
  assign out_timer_action      = tmr_r;
  assign out_outstanding_count = cnt_r;
  assign out_last_result       = last_r;

endmodule

// File: design/go_back_n_sender_window.sv
// Go-Back-N sender window. Send and ack commands give one result each; up to one
// command per cycle is taken while results drain. A timeout with packets outstanding
// first reads the buffer at the base, then gives one replayed packet per cycle while
// the output is not stalled, at most four; the packet buffer port sets that pace.
// Reset is synchronous, active low: base, next sequence and queue clear, window is 4.
// The packet buffer is not cleared; only entries already written are ever replayed.
module go_back_n_sender_window #(
  parameter int SEQ_SPACE     = gbn_pkg::GBN_SEQ_SPACE,
  parameter int PAYLOAD_WIDTH = gbn_pkg::GBN_PAYLOAD_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [gbn_pkg::ADDR_W-1:0] paddr,
  input  logic [gbn_pkg::DATA_W-1:0] pwdata,
  output logic [gbn_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [gbn_pkg::CMD_W-1:0]  in_command,
  input  logic [gbn_pkg::PAY_W-1:0]  in_payload,
  input  logic [gbn_pkg::LEN_W-1:0]  in_payload_length,
  input  logic [gbn_pkg::SQF_W-1:0]  in_ack_sequence,
  input  logic                       in_ack_checksum_good,
  input  logic                       in_ack_type_is_ack,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [gbn_pkg::KND_W-1:0]  out_result_kind,
  output logic [gbn_pkg::SQF_W-1:0]  out_sequence_number,
  output logic [gbn_pkg::PAY_W-1:0]  out_payload,
  output logic [gbn_pkg::LEN_W-1:0]  out_length,
  output logic [gbn_pkg::TMR_W-1:0]  out_timer_action,
  output logic [gbn_pkg::SQF_W-1:0]  out_outstanding_count,
  output logic                       out_last_result
);
  import gbn_pkg::*;

  logic [WIN_W-1:0] window_size_r;
  logic             cfg_write;
  logic             q_full;
  logic             q_push;
  op_t              q_op;
  logic             head_valid;
  op_t              head_op;
  logic             op_pop;

  // Register index sits in paddr[2]; the low byte-offset bits are ignored.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WINDOW_RESET;
    end else if (cfg_write && (paddr[2] == REG_WINDOW_SIZE)) begin
      window_size_r <= pwdata[WIN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_WINDOW_SIZE) ? DATA_W'(window_size_r) : '0;

  gbn_front #(
    .SEQ_SPACE (SEQ_SPACE)
  ) u_front (
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_command           (in_command),
    .in_payload           (in_payload),
    .in_payload_length    (in_payload_length),
    .in_ack_sequence      (in_ack_sequence),
    .in_ack_checksum_good (in_ack_checksum_good),
    .in_ack_type_is_ack   (in_ack_type_is_ack),
    .q_full               (q_full),
    .q_push               (q_push),
    .q_op                 (q_op)
  );

  gbn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_op),
    .full       (q_full),
    .pop        (op_pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  gbn_back #(
    .SEQ_SPACE     (SEQ_SPACE),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .window_size           (window_size_r),
    .op_valid              (head_valid),
    .op                    (head_op),
    .op_pop                (op_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_result_kind       (out_result_kind),
    .out_sequence_number   (out_sequence_number),
    .out_payload           (out_payload),
    .out_length            (out_length),
    .out_timer_action      (out_timer_action),
    .out_outstanding_count (out_outstanding_count),
    .out_last_result       (out_last_result)
  );

endmodule

// File: design/gbn_checker.sv
// Port-level checks for the Go-Back-N sender window, bound to the top level.
// Depends on gbn_pkg and the assertion macros header.
`include "go_back_n_sender_window_macros.svh"

module gbn_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [gbn_pkg::KND_W-1:0] out_result_kind,
  input logic [gbn_pkg::SQF_W-1:0] out_sequence_number,
  input logic [gbn_pkg::PAY_W-1:0] out_payload,
  input logic [gbn_pkg::LEN_W-1:0] out_length,
  input logic [gbn_pkg::TMR_W-1:0] out_timer_action,
  input logic [gbn_pkg::SQF_W-1:0] out_outstanding_count,
  input logic                      out_last_result
);
  import gbn_pkg::*;

  // Only a transmitted packet carries payload and length.
  `GBN_ASSERT_SAME(a_idle_fields_zero, out_valid && (out_result_kind != RES_TRANSMIT), (out_payload == '0) && (out_length == '0), "non-transmit result with payload")

  // Only a replay burst produces results that are not the last of their command.
  `GBN_ASSERT_SAME(a_nonlast_is_replay, out_valid && !out_last_result, (out_result_kind == RES_TRANSMIT) && (out_timer_action != TMR_STOP), "non-last result is not a replayed packet")

  // The window holds no more than a replay burst; transmits have nonzero length.
  `GBN_ASSERT_SAME(a_count_bound, out_valid, (out_outstanding_count <= BURST_LIMIT) && (out_length != '0 || out_result_kind != RES_TRANSMIT), "outstanding count or packet length out of range")

  // A stalled result is held until it is taken.
  `GBN_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(out_result_kind) && $stable(out_sequence_number) && $stable(out_payload) && $stable(out_last_result), "stalled result changed")

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_result_kind       (out_result_kind),
  .out_sequence_number   (out_sequence_number),
  .out_payload           (out_payload),
  .out_length            (out_length),
  .out_timer_action      (out_timer_action),
  .out_outstanding_count (out_outstanding_count),
  .out_last_result       (out_last_result)
);

// File: dv/testbench.sv
// Self-checking testbench for the Go-Back-N sender window: directed and random commands,
// predicted results checked in order, window register changed between phases.
// Depends on gbn_pkg and go_back_n_sender_window.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gbn_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam int NUM_PHASES = 6;
  localparam logic [WIN_W-1:0] PHASE_WINDOW [NUM_PHASES] =
    '{3'd1, 3'd7, 3'd3, 3'd0, 3'd2, 3'd6};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{30, 40, 35, 15, 35, 50};
  localparam logic [ADDR_W-1:0] WINDOW_ADDR = {REG_WINDOW_SIZE, 2'b00};

  typedef struct packed {
    cmd_t              command;
    logic [PAY_W-1:0]  payload;
    logic [LEN_W-1:0]  length;
    logic [SQF_W-1:0]  ack_seq;
    logic              ack_checksum_good;
    logic              ack_type_is_ack;
  } window_cmd_t;

  typedef struct packed {
    res_kind_t         kind;
    logic [SQF_W-1:0]  seq;
    logic [PAY_W-1:0]  payload;
    logic [LEN_W-1:0]  length;
    tmr_t              timer;
    logic [SQF_W-1:0]  outstanding;
    logic              last;
  } window_report_t;

  typedef struct packed {
    logic [WIN_W-1:0]                     win_size;
    logic [SQF_W-1:0]                     base;
    logic [SQF_W-1:0]                     nxt;
    logic [GBN_SEQ_SPACE-1:0][PAY_W-1:0]  pay;
    logic [GBN_SEQ_SPACE-1:0][LEN_W-1:0]  len;
  } window_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CMD_W-1:0] in_command = '0;
  logic [PAY_W-1:0] in_payload = '0;
  logic [LEN_W-1:0] in_payload_length = '0;
  logic [SQF_W-1:0] in_ack_sequence = '0;
  logic in_ack_checksum_good = 1'b0;
  logic in_ack_type_is_ack = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [KND_W-1:0] out_result_kind;
  logic [SQF_W-1:0] out_sequence_number;
  logic [PAY_W-1:0] out_payload;
  logic [LEN_W-1:0] out_length;
  logic [TMR_W-1:0] out_timer_action;
  logic [SQF_W-1:0] out_outstanding_count;
  logic out_last_result;

  window_cmd_t commands_to_send[$];
  window_report_t reports_due[$];
  window_state_t window_now;
  window_state_t window_plan;
  window_cmd_t cmd_on_port;
  int send_idle_pct = 21;
  int recv_stall_pct = 75;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int mismatches = 0;
  int cycle_count = 0;

  go_back_n_sender_window dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_payload(in_payload),
    .in_payload_length(in_payload_length), .in_ack_sequence(in_ack_sequence),
    .in_ack_checksum_good(in_ack_checksum_good),
    .in_ack_type_is_ack(in_ack_type_is_ack),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_kind(out_result_kind), .out_sequence_number(out_sequence_number),
    .out_payload(out_payload), .out_length(out_length),
    .out_timer_action(out_timer_action), .out_outstanding_count(out_outstanding_count),
    .out_last_result(out_last_result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic window_report_t make_report(res_kind_t kind, logic [SQF_W-1:0] seq,
                                                 logic [PAY_W-1:0] pay,
                                                 logic [LEN_W-1:0] len, tmr_t timer,
                                                 logic [SQF_W-1:0] cnt, logic last);
    window_report_t r;
    r.kind = kind;
    r.seq = seq;
    r.payload = pay;
    r.length = len;
    r.timer = timer;
    r.outstanding = cnt;
    r.last = last;
    return r;
  endfunction

  // Applies one command to the window state and returns how many reports it causes.
  function automatic int window_step(inout window_state_t st, input window_cmd_t it,
                                     output window_report_t [3:0] res);
    logic [SQF_W-1:0] cnt;
    logic [SQF_W-1:0] ack_gap;
    logic [SQF_W-1:0] s;
    logic [WIN_W-1:0] win;
    int n;
    res = '0;
    n = 1;
    // Sequence arithmetic wraps at the 3-bit width, which is the sequence space.
    cnt = st.nxt - st.base;
    // A timeout can replay at most a burst, so the window is clamped to it.
    win = (st.win_size > WIN_W'(BURST_LIMIT)) ? WIN_W'(BURST_LIMIT) : st.win_size;
    case (it.command)
      CMD_SEND: begin
        if (it.length != '0 && int'(it.length) <= MAX_LENGTH && cnt < win) begin
          st.pay[st.nxt] = it.payload;
          st.len[st.nxt] = it.length;
          res[0] = make_report(RES_TRANSMIT, st.nxt, it.payload, it.length,
                               (cnt == '0) ? TMR_START : TMR_NONE, cnt + 1'b1, 1'b1);
          st.nxt = st.nxt + 1'b1;
        end else begin
          res[0] = make_report(RES_REFUSED, st.base, '0, '0, TMR_NONE, cnt, 1'b1);
        end
      end
      CMD_ACK: begin
        ack_gap = it.ack_seq - st.base;
        if (it.ack_checksum_good && it.ack_type_is_ack && ack_gap < win && ack_gap < cnt) begin
          st.base = it.ack_seq + 1'b1;
          res[0] = make_report(RES_ACK_ACCEPTED, st.base, '0, '0,
                               (st.nxt == st.base) ? TMR_STOP : TMR_NONE,
                               st.nxt - st.base, 1'b1);
        end else begin
          res[0] = make_report(RES_ACK_IGNORED, st.base, '0, '0, TMR_NONE, cnt, 1'b1);
        end
      end
      CMD_TIMEOUT: begin
        if (cnt == '0) begin
          res[0] = make_report(RES_IDLE_TIMEOUT, st.base, '0, '0, TMR_NONE, '0, 1'b1);
        end else begin
          n = (cnt > BURST_LIMIT) ? BURST_LIMIT : int'(cnt);
          for (int i = 0; i < n; i++) begin
            s = st.base + SQF_W'(i);
            res[i] = make_report(RES_TRANSMIT, s, st.pay[s], st.len[s],
                                 (i == 0) ? TMR_START : TMR_NONE, cnt, i == n - 1);
          end
        end
      end
      default: begin
        n = 0;
      end
    endcase
    return n;
  endfunction

  function automatic window_cmd_t make_cmd(cmd_t command, logic [PAY_W-1:0] pay,
                                           logic [LEN_W-1:0] len, logic [SQF_W-1:0] seq,
                                           logic ck_good, logic is_ack);
    window_cmd_t c;
    c.command = command;
    c.payload = pay;
    c.length = len;
    c.ack_seq = seq;
    c.ack_checksum_good = ck_good;
    c.ack_type_is_ack = is_ack;
    return c;
  endfunction

  // The plan state runs ahead of the port so that acks can be aimed into the window.
  task automatic queue_cmd(input window_cmd_t c);
    window_report_t [3:0] unused;
    void'(window_step(window_plan, c, unused));
    commands_to_send.push_back(c);
  endtask

  task automatic add_random_cmds(input int target);
    window_cmd_t c;
    logic [SQF_W-1:0] cnt;
    int added;
    int roll;
    added = 0;
    while (added < target) begin
      cnt = window_plan.nxt - window_plan.base;
      roll = $urandom_range(99);
      c = make_cmd(CMD_SEND, $urandom, LEN_W'($urandom), SQF_W'($urandom),
                   1'($urandom), 1'($urandom));
      if (roll < 45) begin
        if ($urandom_range(9) != 0) begin
          c.length = LEN_W'($urandom_range(255, 1));
        end
      end else if (roll < 80) begin
        c.command = CMD_ACK;
        // Most acks are well formed and land on an outstanding packet.
        if (cnt != '0 && roll < 72) begin
          c.ack_seq = window_plan.base + SQF_W'($urandom_range(int'(cnt) - 1));
          c.ack_checksum_good = 1'b1;
          c.ack_type_is_ack = 1'b1;
        end
      end else if (roll < 92) begin
        c.command = CMD_TIMEOUT;
      end else begin
        c.command = cmd_t'($urandom_range(3));
      end
      queue_cmd(c);
      if (c.command != CMD_NONE) begin
        added++;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  task automatic wait_for_drain();
    // Sampled between edges so that the driver and monitor have settled.
    while (commands_to_send.size() != 0 || in_valid || reports_due.size() != 0) begin
      @(negedge clk);
    end
    // A command with no report may still be in flight.
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] w);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= WINDOW_ADDR;
    pwdata <= DATA_W'(w);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    window_now.win_size = w;
    window_plan.win_size = w;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("window_size", w, prdata[WIN_W-1:0]);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Driver: a new command is offered only when the port is free or the last transfer
  // completed at this edge.
  always @(posedge clk) begin : drive_cmds
    window_report_t [3:0] burst;
    int n;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        n = window_step(window_now, cmd_on_port, burst);
        for (int i = 0; i < n; i++) begin
          reports_due.push_back(burst[i]);
        end
      end
      if (!in_valid || !in_stall) begin
        if (commands_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd_on_port = commands_to_send.pop_front();
          in_command <= cmd_on_port.command;
          in_payload <= cmd_on_port.payload;
          in_payload_length <= cmd_on_port.length;
          in_ack_sequence <= cmd_on_port.ack_seq;
          in_ack_checksum_good <= cmd_on_port.ack_checksum_good;
          in_ack_type_is_ack <= cmd_on_port.ack_type_is_ack;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_reports
    window_report_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (reports_due.size() == 0) begin
        $error("result_kind: no result expected, got %0h", out_result_kind);
        mismatches++;
      end else begin
        e = reports_due.pop_front();
        check_field("result_kind", e.kind, out_result_kind);
        check_field("sequence_number", e.seq, out_sequence_number);
        check_field("out_payload", e.payload, out_payload);
        check_field("out_length", e.length, out_length);
        check_field("timer_action", e.timer, out_timer_action);
        check_field("outstanding_count", e.outstanding, out_outstanding_count);
        check_field("last_result", e.last, out_last_result);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    window_now = '0;
    window_now.win_size = WINDOW_RESET;
    window_plan = window_now;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Empty window corner cases, then fill the reset window of four.
    queue_cmd(make_cmd(CMD_TIMEOUT, '0, '0, '0, 1'b0, 1'b0));
    queue_cmd(make_cmd(CMD_ACK, '0, '0, 3'd0, 1'b1, 1'b1));
    queue_cmd(make_cmd(CMD_SEND, 32'h1111_2222, 8'd0, '0, 1'b0, 1'b0));
    queue_cmd(make_cmd(CMD_SEND, 32'h0000_0000, 8'd1, '0, 1'b0, 1'b0));
    queue_cmd(make_cmd(CMD_SEND, 32'hffff_ffff, 8'd255, 3'd7, 1'b1, 1'b1));
    queue_cmd(make_cmd(CMD_SEND, 32'ha5a5_a5a5, 8'h80, '0, 1'b0, 1'b0));
    queue_cmd(make_cmd(CMD_SEND, 32'h5a5a_5a5a, 8'h7f, '0, 1'b0, 1'b0));
    queue_cmd(make_cmd(CMD_SEND, 32'h1234_5678, 8'd10, '0, 1'b0, 1'b0));
    // A full window replays the longest burst.
    queue_cmd(make_cmd(CMD_TIMEOUT, '0, '0, '0, 1'b0, 1'b0));
    queue_cmd(make_cmd(CMD_ACK, '0, '0, 3'd0, 1'b0, 1'b1));
    queue_cmd(make_cmd(CMD_ACK, '0, '0, 3'd0, 1'b1, 1'b0));
    queue_cmd(make_cmd(CMD_ACK, '0, '0, 3'd5, 1'b1, 1'b1));
    queue_cmd(make_cmd(CMD_ACK, '0, '0, 3'd1, 1'b1, 1'b1));
    queue_cmd(make_cmd(CMD_NONE, 32'hdead_0003, 8'd3, 3'd3, 1'b1, 1'b1));
    queue_cmd(make_cmd(CMD_SEND, 32'hdead_beef, 8'd42, '0, 1'b0, 1'b0));
    queue_cmd(make_cmd(CMD_TIMEOUT, '0, '0, '0, 1'b0, 1'b0));
    queue_cmd(make_cmd(CMD_ACK, '0, '0, 3'd4, 1'b1, 1'b1));
    // Sends across the wrap of the sequence space, then a replay across it.
    queue_cmd(make_cmd(CMD_SEND, 32'h0000_0005, 8'd5, '0, 1'b0, 1'b0));
    queue_cmd(make_cmd(CMD_SEND, 32'h0000_0006, 8'd6, '0, 1'b0, 1'b0));
    queue_cmd(make_cmd(CMD_SEND, 32'h0000_0007, 8'd7, '0, 1'b0, 1'b0));
    queue_cmd(make_cmd(CMD_SEND, 32'h8000_0000, 8'd8, '0, 1'b0, 1'b0));
    queue_cmd(make_cmd(CMD_ACK, '0, '0, 3'd5, 1'b1, 1'b1));
    queue_cmd(make_cmd(CMD_TIMEOUT, '0, '0, '0, 1'b0, 1'b0));
    wait_for_drain();

    // Three packets stay outstanding, so the first phase shrinks the window below them.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 2) begin
        send_idle_pct = 75;
        recv_stall_pct = 21;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      write_window(PHASE_WINDOW[p]);
      add_random_cmds(PHASE_ITEMS[p]);
      // Hold results back long enough that the block fills and stalls its input.
      if (p == NUM_PHASES - 1) begin
        hold_requests++;
      end
      wait_for_drain();
    end

    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
